@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on the rising clock, muted while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: whenever cond holds, expr must hold in the same cycle.
`define ASSERT_IMPLY(label, cond, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error(msg);

`endif

@@ hw/rtl/mefq_pkg.sv @@
// Types, codes and helper functions shared by the MIDI event filter queue.
package mefq_pkg;

  // Input item kinds.
  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Upper nibble of the status byte for the message types that are kept.
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_CTRL_CHG = 4'hB;

  // Depth of the command queue between the front and the back end.
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_IDX_W = 1;
  localparam int unsigned CMDQ_CNT_W = 2;

  typedef enum logic [2:0] {
    RES_PUSHED    = 3'd0,
    RES_FILTERED  = 3'd1,
    RES_DROPPED   = 3'd2,
    RES_DELIVERED = 3'd3,
    RES_EMPTY     = 3'd4,
    RES_FLUSHED   = 3'd5
  } res_code_e;

  typedef enum logic [1:0] {
    CLS_IGNORED  = 2'd0,
    CLS_NOTE_ON  = 2'd1,
    CLS_NOTE_OFF = 2'd2,
    CLS_CTRL_CHG = 2'd3
  } cls_e;

  // One ring entry: the three message bytes and the capture time.
  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [63:0] ts;
  } entry_t;

  // One command handed from the front to the back end.
  typedef struct packed {
    logic   kind;
    cls_e   cls;
    entry_t msg;
  } cmd_t;

  // Command queue status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic draining;
    logic pend;
  } eng_stat_t;

  // One result beat.
  typedef struct packed {
    res_code_e   code;
    cls_e        cls;
    logic [3:0]  channel;
    logic [6:0]  number;
    logic [6:0]  value;
    logic [7:0]  raw_status;
    logic [7:0]  raw_first;
    logic [7:0]  raw_second;
    logic [63:0] time_stamp;
    logic        last;
  } res_t;

  // Classify a message; a Note On with zero velocity counts as Note Off.
  function automatic cls_e classify(input logic [7:0] st, input logic [7:0] d2);
    cls_e cls;
    cls = CLS_IGNORED;
    if (st[7]) begin
      unique case (st[7:4])
        STAT_NOTE_ON:  cls = (d2[6:0] == 7'd0) ? CLS_NOTE_OFF : CLS_NOTE_ON;
        STAT_NOTE_OFF: cls = CLS_NOTE_OFF;
        STAT_CTRL_CHG: cls = CLS_CTRL_CHG;
        default:       cls = CLS_IGNORED;
      endcase
    end
    return cls;
  endfunction

  // Build a result beat from a message and its code.
  function automatic res_t make_result(input res_code_e code, input entry_t msg,
                                       input logic last);
    res_t r;
    cls_e cls;
    cls          = classify(msg.status, msg.second);
    r.code       = code;
    r.cls        = cls;
    r.channel    = msg.status[7] ? msg.status[3:0] : 4'd0;
    r.number     = (cls != CLS_IGNORED) ? msg.first[6:0] : 7'd0;
    r.value      = (cls != CLS_IGNORED) ? msg.second[6:0] : 7'd0;
    r.raw_status = msg.status;
    r.raw_first  = msg.first;
    r.raw_second = msg.second;
    r.time_stamp = msg.ts;
    r.last       = last;
    return r;
  endfunction

endpackage

@@ hw/rtl/mefq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module mefq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mefq_front.sv @@
// Front end: accepts items, classifies messages and holds the delivery register.
module mefq_front import mefq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        kind_i,
  input  logic [7:0]  status_byte_i,
  input  logic [7:0]  first_data_i,
  input  logic [7:0]  second_data_i,
  input  logic [63:0] timestamp_us_i,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  q_stat_t     q_stat_i,
  output logic        busy_o,
  output logic        push_o,
  output cmd_t        cmd_o,
  output logic        deliver_o
);

  logic deliver_q;

  // Delivery enable register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deliver_q <= 1'b0;
    end else if (cfg_we_i) begin
      deliver_q <= cfg_wdata_i;
    end
  end

  // An item is taken whenever the command queue has room.
  assign busy_o = q_stat_i.full;
  assign push_o = start_i && !q_stat_i.full;

  // Classify the message and form the command.
  always_comb begin
    cmd_o.kind       = kind_i;
    cmd_o.cls        = (kind_i == KIND_PUSH) ? classify(status_byte_i, second_data_i)
                                             : CLS_IGNORED;
    cmd_o.msg.status = status_byte_i;
    cmd_o.msg.first  = first_data_i;
    cmd_o.msg.second = second_data_i;
    cmd_o.msg.ts     = timestamp_us_i;
  end

  assign deliver_o = deliver_q;

endmodule

@@ hw/rtl/mefq_cmd_queue.sv @@
// Short command queue that decouples the front end from the ring engine.
module mefq_cmd_queue import mefq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  cmd_t                  slot_q [CMDQ_DEPTH];
  logic [CMDQ_IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [CMDQ_IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign cmd_o        = slot_q[rd_idx_q];

  // Pointer and fill count update.
  always_comb begin
    wr_idx_d = push_i ? wr_idx_q + 1'b1 : wr_idx_q;
    rd_idx_d = pop_i ? rd_idx_q + 1'b1 : rd_idx_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      cnt_q    <= cnt_d;
    end
  end

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_idx_q] <= cmd_i;
    end
  end

endmodule

@@ hw/rtl/mefq_engine.sv @@
// Back end: owns the message ring, executes pushes and walks drains.
module mefq_engine import mefq_pkg::*; #(
  parameter int unsigned RING_DEPTH = 64,
  localparam int unsigned PTR_W = $clog2(RING_DEPTH)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  q_stat_t   q_stat_i,
  input  logic      deliver_i,
  output logic      pop_o,
  output logic      res_valid_o,
  output res_t      res_o,
  output eng_stat_t stat_o
);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } eng_state_e;

  eng_state_e       state_q, state_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [PTR_W-1:0] wr_q, wr_d;
  res_code_e        code_q, code_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;
  logic             res_valid_q;
  res_t             res_q, res_d;

  logic [PTR_W-1:0] rd_nxt, wr_nxt;
  logic             ring_full;
  logic             ram_we, ram_re;
  entry_t           ram_rdata;

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rd_nxt    = wrap_next(rd_q);
  assign wr_nxt    = wrap_next(wr_q);
  assign ring_full = (wr_nxt == rd_q);

  // A command is taken only while no drained entry is still on its way out.
  assign pop_o  = (state_q == ST_RUN) && !q_stat_i.empty && !pend_q;
  assign ram_we = pop_o && (cmd_i.kind == KIND_PUSH) && (cmd_i.cls != CLS_IGNORED)
                  && !ring_full;
  assign ram_re = (state_q == ST_DRAIN);

  mefq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (cmd_i.msg),
    .re_i    (ram_re),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer: executes pushes and drains one ring read per cycle.
  always_comb begin
    state_d     = state_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    code_d      = code_q;
    pend_d      = 1'b0;
    pend_last_d = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (pop_o) begin
          if (cmd_i.kind == KIND_PUSH) begin
            if (ram_we) begin
              wr_d = wr_nxt;
            end
          end else if (rd_q != wr_q) begin
            state_d = ST_DRAIN;
            code_d  = deliver_i ? RES_DELIVERED : RES_FLUSHED;
          end
        end
      end
      ST_DRAIN: begin
        rd_d        = rd_nxt;
        pend_d      = 1'b1;
        pend_last_d = (rd_nxt == wr_q);
        if (rd_nxt == wr_q) begin
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Result beat selection: a drained entry, a push outcome or an empty drain.
  always_comb begin
    res_d = '0;
    if (pend_q) begin
      res_d = make_result(code_q, ram_rdata, pend_last_q);
    end else if (cmd_i.kind == KIND_PUSH) begin
      if (cmd_i.cls == CLS_IGNORED) begin
        res_d = make_result(RES_FILTERED, cmd_i.msg, 1'b1);
      end else if (ring_full) begin
        res_d = make_result(RES_DROPPED, cmd_i.msg, 1'b1);
      end else begin
        res_d = make_result(RES_PUSHED, cmd_i.msg, 1'b1);
      end
    end else begin
      res_d.code = RES_EMPTY;
      res_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      rd_q        <= '0;
      wr_q        <= '0;
      code_q      <= RES_FLUSHED;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      code_q      <= code_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      res_valid_q <= pend_q || (pop_o && !(cmd_i.kind == KIND_DRAIN && rd_q != wr_q));
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o     = res_valid_q;
  assign res_o           = res_q;
  assign stat_o.draining = (state_q == ST_DRAIN);
  assign stat_o.pend     = pend_q;

endmodule

@@ hw/rtl/midi_event_filter_fifo_unit.sv @@
// Top level of the MIDI event filter queue: front end, command queue, ring engine.
// Pushes sustain 1 per cycle while no drain is in progress. A drain of N queued entries
// yields N beats, one per cycle (one ring RAM read per beat), or one empty beat if the ring
// is empty; busy is high while the 2-entry command queue is full.
// Reset clears the pointers, queue and delivery register; ring contents are not cleared.
`include "assert_macros.svh"

module midi_event_filter_fifo_unit import mefq_pkg::*; #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        kind_i,
  input  logic [7:0]  status_byte_i,
  input  logic [7:0]  first_data_i,
  input  logic [7:0]  second_data_i,
  input  logic [63:0] timestamp_us_i,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  output logic        result_valid_o,
  output logic [2:0]  result_code_o,
  output logic [1:0]  event_class_o,
  output logic [3:0]  channel_o,
  output logic [6:0]  number_o,
  output logic [6:0]  value_o,
  output logic [7:0]  raw_status_o,
  output logic [7:0]  raw_first_o,
  output logic [7:0]  raw_second_o,
  output logic [63:0] time_stamp_o,
  output logic        last_o
);

  logic      push;
  logic      pop;
  logic      deliver;
  cmd_t      cmd_in;
  cmd_t      cmd_head;
  q_stat_t   q_stat;
  eng_stat_t eng_stat;
  res_t      res;

  mefq_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .kind_i         (kind_i),
    .status_byte_i  (status_byte_i),
    .first_data_i   (first_data_i),
    .second_data_i  (second_data_i),
    .timestamp_us_i (timestamp_us_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_stat_i       (q_stat),
    .busy_o         (busy_o),
    .push_o         (push),
    .cmd_o          (cmd_in),
    .deliver_o      (deliver)
  );

  mefq_cmd_queue u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_head),
    .stat_o (q_stat)
  );

  mefq_engine #(
    .RING_DEPTH (RING_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .q_stat_i    (q_stat),
    .deliver_i   (deliver),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .res_o       (res),
    .stat_o      (eng_stat)
  );

  // Result beat onto the ports.
  assign result_code_o = res.code;
  assign event_class_o = res.cls;
  assign channel_o     = res.channel;
  assign number_o      = res.number;
  assign value_o       = res.value;
  assign raw_status_o  = res.raw_status;
  assign raw_first_o   = res.raw_first;
  assign raw_second_o  = res.raw_second;
  assign time_stamp_o  = res.time_stamp;
  assign last_o        = res.last;

  // A beat only follows a command pop or an outstanding ring read.
  `ASSERT_CLK(a_beat_has_source, result_valid_o |-> $past(!q_stat.empty || eng_stat.pend),
    "result beat without a command or ring read behind it")

  // Push outcomes and empty drains are always single, final beats.
  `ASSERT_IMPLY(a_single_beat_last,
    result_valid_o && (result_code_o == RES_PUSHED || result_code_o == RES_FILTERED ||
                       result_code_o == RES_DROPPED || result_code_o == RES_EMPTY),
    last_o, "single-beat result not marked last")

  // No command is popped while a drain walk is in progress.
  `ASSERT_IMPLY(a_no_pop_in_drain, eng_stat.draining || eng_stat.pend, !pop,
    "command popped during a drain")

endmodule

@@ test/midi_event_filter_fifo_unit_test.sv @@
// Self-checking testbench for the MIDI event filter queue top level.
`timescale 1ns / 100ps

module midi_event_filter_fifo_unit_test import mefq_pkg::*;;

  localparam int unsigned RING_SLOTS = 64;

  // Status nibbles of message types that the queue does not keep.
  localparam logic [3:0] STAT_POLY_PRESS = 4'hA;
  localparam logic [3:0] STAT_PROG_CHG   = 4'hC;
  localparam logic [3:0] STAT_CHAN_PRESS = 4'hD;
  localparam logic [3:0] STAT_PITCH_BEND = 4'hE;
  localparam logic [3:0] STAT_SYSTEM     = 4'hF;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start_i        = 1'b0;
  logic        kind_i         = KIND_PUSH;
  logic [7:0]  status_byte_i  = 8'h00;
  logic [7:0]  first_data_i   = 8'h00;
  logic [7:0]  second_data_i  = 8'h00;
  logic [63:0] timestamp_us_i = 64'h0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_wdata_i    = 1'b0;
  logic        busy_o;
  logic        result_valid_o;
  logic [2:0]  result_code_o;
  logic [1:0]  event_class_o;
  logic [3:0]  channel_o;
  logic [6:0]  number_o;
  logic [6:0]  value_o;
  logic [7:0]  raw_status_o;
  logic [7:0]  raw_first_o;
  logic [7:0]  raw_second_o;
  logic [63:0] time_stamp_o;
  logic        last_o;

  // Predicted state of the queue.
  logic [23:0] ring_msg [RING_SLOTS];
  logic [63:0] ring_ts [RING_SLOTS];
  int unsigned ring_rd    = 0;
  int unsigned ring_wr    = 0;
  bit          deliver_on = 1'b0;

  // Beats still owed by the block, oldest first.
  res_t expected_beats[$];

  int  errors        = 0;
  int  pushes_sent   = 0;
  int  drains_sent   = 0;
  int  beats_checked = 0;
  int  cfg_writes    = 0;
  bit  gaps_on       = 1'b1;

  midi_event_filter_fifo_unit #(
    .RING_DEPTH(RING_SLOTS)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .kind_i,
    .status_byte_i,
    .first_data_i,
    .second_data_i,
    .timestamp_us_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .result_valid_o,
    .result_code_o,
    .event_class_o,
    .channel_o,
    .number_o,
    .value_o,
    .raw_status_o,
    .raw_first_o,
    .raw_second_o,
    .time_stamp_o,
    .last_o
  );

  always #5 clk_i = ~clk_i;

  // Ring slot that follows p, wrapping at the end.
  function automatic int unsigned ring_next(input int unsigned p);
    return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
  endfunction

  // Message type; a Note On with a zero seven-bit velocity is a Note Off.
  function automatic cls_e message_class(input logic [7:0] st, input logic [7:0] d2);
    if (!st[7]) return CLS_IGNORED;
    case (st[7:4])
      STAT_NOTE_ON:  return (d2[6:0] == 7'd0) ? CLS_NOTE_OFF : CLS_NOTE_ON;
      STAT_NOTE_OFF: return CLS_NOTE_OFF;
      STAT_CTRL_CHG: return CLS_CTRL_CHG;
      default:       return CLS_IGNORED;
    endcase
  endfunction

  // Expected beat for one message; number and value are zero for ignored types.
  function automatic res_t beat_for(input res_code_e code, input logic [7:0] st,
                                    input logic [7:0] d1, input logic [7:0] d2,
                                    input logic [63:0] ts, input logic is_last);
    res_t  b;
    cls_e  c;
    c            = message_class(st, d2);
    b.code       = code;
    b.cls        = c;
    b.channel    = st[7] ? st[3:0] : 4'd0;
    b.number     = (c != CLS_IGNORED) ? d1[6:0] : 7'd0;
    b.value      = (c != CLS_IGNORED) ? d2[6:0] : 7'd0;
    b.raw_status = st;
    b.raw_first  = d1;
    b.raw_second = d2;
    b.time_stamp = ts;
    b.last       = is_last;
    return b;
  endfunction

  // Update the predicted queue for one accepted item and record its beats.
  function automatic void predict_item(input logic kind, input logic [7:0] st,
                                       input logic [7:0] d1, input logic [7:0] d2,
                                       input logic [63:0] ts);
    res_code_e   code;
    int unsigned nxt;
    if (kind == KIND_PUSH) begin
      if (message_class(st, d2) == CLS_IGNORED) begin
        code = RES_FILTERED;
      end else if (ring_next(ring_wr) == ring_rd) begin
        code = RES_DROPPED;
      end else begin
        ring_msg[ring_wr] = {st, d1, d2};
        ring_ts[ring_wr]  = ts;
        ring_wr           = ring_next(ring_wr);
        code              = RES_PUSHED;
      end
      expected_beats.push_back(beat_for(code, st, d1, d2, ts, 1'b1));
    end else if (ring_rd == ring_wr) begin
      expected_beats.push_back(beat_for(RES_EMPTY, 8'h00, 8'h00, 8'h00, 64'h0, 1'b1));
    end else begin
      code = deliver_on ? RES_DELIVERED : RES_FLUSHED;
      while (ring_rd != ring_wr) begin
        nxt = ring_next(ring_rd);
        expected_beats.push_back(beat_for(code, ring_msg[ring_rd][23:16],
                                          ring_msg[ring_rd][15:8], ring_msg[ring_rd][7:0],
                                          ring_ts[ring_rd], nxt == ring_wr));
        ring_rd = nxt;
      end
    end
  endfunction

  // Random status byte of a kept message type on a random channel.
  function automatic logic [7:0] random_kept_status();
    logic [3:0] ch;
    ch = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 2))
      0:       return {STAT_NOTE_ON, ch};
      1:       return {STAT_NOTE_OFF, ch};
      default: return {STAT_CTRL_CHG, ch};
    endcase
  endfunction

  // Random status byte that the queue filters out.
  function automatic logic [7:0] random_ignored_status();
    logic [3:0] ch;
    ch = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(0, 8'h7F));
      1:       return {STAT_POLY_PRESS, ch};
      2:       return {STAT_PROG_CHG, ch};
      3:       return {STAT_CHAN_PRESS, ch};
      4:       return {STAT_PITCH_BEND, ch};
      default: return {STAT_SYSTEM, ch};
    endcase
  endfunction

  // Second data byte, now and then with a zero seven-bit value.
  function automatic logic [7:0] random_second();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] random_stamp();
    return {32'($urandom), 32'($urandom)};
  endfunction

  // Occasional random sender gap while gaps are enabled, start low during the gap.
  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Present one item, wait until the block takes it, then predict its beats.
  // Start stays high afterwards unless a sender gap drops it, so back-to-back items follow.
  task automatic send_item(input logic kind, input logic [7:0] st, input logic [7:0] d1,
                           input logic [7:0] d2, input logic [63:0] ts);
    start_i        <= 1'b1;
    kind_i         <= kind;
    status_byte_i  <= st;
    first_data_i   <= d1;
    second_data_i  <= d2;
    timestamp_us_i <= ts;
    do @(posedge clk_i); while (busy_o);
    predict_item(kind, st, d1, d2, ts);
    if (kind == KIND_PUSH) pushes_sent++;
    else drains_sent++;
    sender_gap();
  endtask

  task automatic send_drain();
    send_item(KIND_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), random_stamp());
  endtask

  task automatic send_random_kept();
    send_item(KIND_PUSH, random_kept_status(), 8'($urandom), random_second(),
              random_stamp());
  endtask

  task automatic send_random_ignored();
    send_item(KIND_PUSH, random_ignored_status(), 8'($urandom), 8'($urandom),
              random_stamp());
  endtask

  // Stop sending and wait until every owed beat has come out.
  task automatic wait_quiet();
    start_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Write the delivery register while the block is idle.
  task automatic write_delivery(input bit on);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    @(posedge clk_i);
    deliver_on = on;
    cfg_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // Field extremes, every message class and every drain outcome.
  task automatic test_directed();
    write_delivery(1'b0);
    send_drain();
    send_item(KIND_PUSH, 8'h00, 8'h00, 8'h00, 64'h0);
    send_item(KIND_PUSH, 8'h7F, 8'hFF, 8'hFF, '1);
    send_item(KIND_PUSH, {STAT_SYSTEM, 4'hF}, 8'h12, 8'h34, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(KIND_PUSH, {STAT_POLY_PRESS, 4'h5}, 8'h40, 8'h40, 64'h5555_5555_5555_5555);
    send_item(KIND_PUSH, {STAT_NOTE_ON, 4'h0}, 8'h00, 8'h7F, 64'h0);
    // Note On with zero velocity, plain and with only the top bit set.
    send_item(KIND_PUSH, {STAT_NOTE_ON, 4'hF}, 8'hFF, 8'h00, '1);
    send_item(KIND_PUSH, {STAT_NOTE_ON, 4'h3}, 8'h3C, 8'h80, 64'h1);
    send_item(KIND_PUSH, {STAT_NOTE_OFF, 4'hF}, 8'hFF, 8'hFF, 64'h8000_0000_0000_0000);
    send_item(KIND_PUSH, {STAT_CTRL_CHG, 4'h7}, 8'h40, 8'h7F, 64'h0123_4567_89AB_CDEF);
    // No consumer: the drain flushes, and a second drain finds the ring empty.
    send_drain();
    send_drain();
    write_delivery(1'b1);
    send_item(KIND_PUSH, {STAT_NOTE_ON, 4'hA}, 8'h80, 8'hFF, 64'hFFFF_0000_FFFF_0000);
    send_item(KIND_PUSH, {STAT_CTRL_CHG, 4'h0}, 8'h7F, 8'h00, 64'h0000_FFFF_0000_FFFF);
    send_item(KIND_PUSH, {STAT_NOTE_OFF, 4'h1}, 8'h01, 8'h01, 64'h2);
    send_drain();
    send_drain();
  endtask

  // Fill the ring to its one-empty-slot limit, overflow it, then drain it all.
  task automatic test_ring_full();
    write_delivery(1'b1);
    repeat (RING_SLOTS - 1) send_random_kept();
    send_random_kept();
    send_random_kept();
    send_random_ignored();
    send_drain();
    send_drain();
  endtask

  // Mostly kept messages with random content, some filtered ones and drains.
  task automatic test_random_phase(input bit on, input bit gaps, input int count);
    int unsigned pick;
    write_delivery(on);
    gaps_on = gaps;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) send_drain();
      else if (pick < 25) send_random_ignored();
      else send_random_kept();
    end
    send_drain();
  endtask

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Every result beat is checked against the oldest owed beat.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got code %0d",
                 $time, result_code_o);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        compare_field("result_code", want.code, result_code_o);
        compare_field("event_class", want.cls, event_class_o);
        compare_field("channel", want.channel, channel_o);
        compare_field("number", want.number, number_o);
        compare_field("value", want.value, value_o);
        compare_field("raw_status", want.raw_status, raw_status_o);
        compare_field("raw_first", want.raw_first, raw_first_o);
        compare_field("raw_second", want.raw_second, raw_second_o);
        compare_field("time_stamp", want.time_stamp, time_stamp_o);
        compare_field("last", want.last, last_o);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_ring_full();
    test_random_phase(1'b0, 1'b1, 20);
    test_random_phase(1'b1, 1'b1, 20);
    test_random_phase(1'b0, 1'b0, 20);
    wait_quiet();
    $display("Sent %0d pushes and %0d drains over %0d register writes.",
             pushes_sent, drains_sent, cfg_writes);
    $display("Checked %0d result beats, %0d mismatches.", beats_checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
